### rtl/sljf_pkg.sv
// Shared types, constants and helpers of the shortest/longest job first scheduler.
`default_nettype none

package sljf_pkg;

  // Number of cells in the ready queue.
  localparam int unsigned QueueDepth = 16;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // Input command codes.
  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  // Result kinds.
  typedef enum logic {
    KIND_DONE   = 1'b0,
    KIND_REJECT = 1'b1
  } kind_e;

  // Word index of the mode register.
  localparam logic REG_LONGEST_FIRST = 1'b0;

  // One queued job.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  arrival;
  } entry_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
    logic longest_first;
  } ctrl_t;

  // True when a fresh job is ordered ahead of a queued one.
  function automatic logic goes_before(logic lf, logic [BurstW-1:0] fresh,
                                       logic [BurstW-1:0] queued);
    goes_before = lf ? (fresh > queued) : (fresh < queued);
  endfunction

endpackage

`default_nettype wire

### rtl/shortest_longest_job_first_scheduler_top.sv
// Top level: configuration port, running job, time counter and result register.
//
// Usage: each input transaction is either a job arrival (cmd_i = 0, with
// job_id_i and burst_length_i) or one time tick (cmd_i = 1). An arrival is
// placed into a sorted queue of cells in the cycle it is accepted; a tick
// dispatches the queue head when the processor is idle, runs the current job
// one unit and advances the time counter. A completed job or a rejected
// arrival (queue full) yields one result transaction, held in an output
// register and visible the cycle after the input was accepted.
// Throughput is one input transaction per cycle while in_stall_o is low, set
// by the insert/pop of the cell row; the result register lets a new input
// enter in the same cycle the previous result is taken.
// When the receiver stalls with a result pending, in_stall_o rises and no
// further input is accepted until the result leaves.
// Reset empties the queue, clears the time counter and the running job and
// selects shortest burst first. The mode register (byte address 0) may be
// written only while the block is idle; it affects later arrivals only.
`default_nettype none

module shortest_longest_job_first_scheduler_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration port.
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [sljf_pkg::AddrW-1:0]       paddr,
  input  wire  [sljf_pkg::DataW-1:0]       pwdata,
  output logic [sljf_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  // Input channel.
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              cmd_i,
  input  wire  [sljf_pkg::IdW-1:0]         job_id_i,
  input  wire  [sljf_pkg::BurstW-1:0]      burst_length_i,
  // Output channel.
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             result_kind_o,
  output logic [sljf_pkg::IdW-1:0]         done_job_id_o,
  output logic [sljf_pkg::TimeW-1:0]       finish_time_o,
  output logic [sljf_pkg::TimeW-1:0]       turnaround_o,
  output logic [sljf_pkg::TimeW-1:0]       wait_time_o
);

  localparam int unsigned BurstW = sljf_pkg::BurstW;
  localparam int unsigned TimeW  = sljf_pkg::TimeW;

  logic                    longest_first_q;
  logic [TimeW-1:0]        now_q;
  logic                    busy_q;
  logic [sljf_pkg::IdW-1:0] cur_id_q;
  logic [BurstW-1:0]       cur_rem_q, cur_burst_q;
  logic [TimeW-1:0]        cur_arr_q;

  logic                    out_valid_q;
  logic                    kind_q;
  logic [sljf_pkg::IdW-1:0] id_q;
  logic [TimeW-1:0]        fin_q, tat_q, wt_q;

  logic                    in_fire, is_tick, is_arrive;
  logic                    cfg_wr;
  sljf_pkg::ctrl_t         ctrl;
  sljf_pkg::entry_t        fresh, head;
  logic                    q_empty, q_full;
  logic                    dispatch, eff_busy, done;
  logic [BurstW-1:0]       eff_rem, eff_burst, rem_next;
  logic [TimeW-1:0]        eff_arr, now_next, tat, wt;
  logic [sljf_pkg::IdW-1:0] eff_id;
  logic                    res_valid;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == sljf_pkg::REG_LONGEST_FIRST) begin
      prdata[0] = longest_first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      longest_first_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == sljf_pkg::REG_LONGEST_FIRST) begin
      longest_first_q <= pwdata[0];
    end
  end

  // Input handshake; the result register frees up when its transaction leaves.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_tick    = in_fire && (cmd_i == sljf_pkg::CMD_TICK);
  assign is_arrive  = in_fire && (cmd_i == sljf_pkg::CMD_ARRIVE);

  // A zero burst counts as one unit.
  always_comb begin
    fresh.id      = job_id_i;
    fresh.burst   = (burst_length_i == '0) ? BurstW'(1) : burst_length_i;
    fresh.arrival = now_q;
  end

  assign dispatch           = is_tick && !busy_q && !q_empty;
  assign ctrl.ins           = is_arrive && !q_full;
  assign ctrl.pop           = dispatch;
  assign ctrl.longest_first = longest_first_q;

  sljf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .fresh_i (fresh),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Running job for this tick: the dispatched head or the current job.
  assign eff_busy  = busy_q || dispatch;
  assign eff_rem   = dispatch ? head.burst   : cur_rem_q;
  assign eff_burst = dispatch ? head.burst   : cur_burst_q;
  assign eff_arr   = dispatch ? head.arrival : cur_arr_q;
  assign eff_id    = dispatch ? head.id      : cur_id_q;
  assign rem_next  = (eff_rem != '0) ? (eff_rem - BurstW'(1)) : '0;
  assign now_next  = now_q + TimeW'(1);
  assign done      = is_tick && eff_busy && (rem_next == '0);
  assign tat       = now_next - eff_arr;
  assign wt        = tat - TimeW'(eff_burst);

  assign res_valid = done || (is_arrive && q_full);

  // Processor state and time counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      busy_q      <= 1'b0;
      cur_id_q    <= '0;
      cur_rem_q   <= '0;
      cur_burst_q <= '0;
      cur_arr_q   <= '0;
    end else if (is_tick) begin
      now_q       <= now_next;
      busy_q      <= eff_busy && !done;
      cur_id_q    <= eff_id;
      cur_rem_q   <= rem_next;
      cur_burst_q <= eff_burst;
      cur_arr_q   <= eff_arr;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      if (done) begin
        kind_q <= sljf_pkg::KIND_DONE;
        id_q   <= eff_id;
        fin_q  <= now_next;
        tat_q  <= tat;
        wt_q   <= wt;
      end else begin
        kind_q <= sljf_pkg::KIND_REJECT;
        id_q   <= job_id_i;
        fin_q  <= '0;
        tat_q  <= '0;
        wt_q   <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign done_job_id_o = id_q;
  assign finish_time_o = fin_q;
  assign turnaround_o  = tat_q;
  assign wait_time_o   = wt_q;

  // An arrival that meets a full queue is reported as rejected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_arrive && q_full |=> out_valid_o && result_kind_o == sljf_pkg::KIND_REJECT)
    else $error("full-queue arrival not rejected");

  // A running job always has work left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cur_rem_q != '0)
    else $error("busy processor with no remaining work");

  // An accepted transaction without a result leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !res_valid |=> !out_valid_o)
    else $error("spurious result");

  // Time advances by one on each tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> now_q == $past(now_q) + TimeW'(1))
    else $error("time counter did not advance on tick");

endmodule

`default_nettype wire

### rtl/sljf_cell.sv
// One slot of the sorted ready queue.
`default_nettype none

module sljf_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sljf_pkg::ctrl_t     ctrl_i,
  input  sljf_pkg::entry_t    fresh_i,
  input  sljf_pkg::entry_t    prev_i,
  input  wire                 prev_valid_i,
  input  sljf_pkg::entry_t    next_i,
  input  wire                 next_valid_i,
  input  wire                 found_i,
  output logic                found_o,
  output sljf_pkg::entry_t    entry_o,
  output logic                valid_o
);

  sljf_pkg::entry_t entry_q, entry_d;
  logic             valid_q, valid_d;
  logic             hit;
  logic             place;

  // The first cell that is empty or ordered behind the fresh job takes it.
  assign hit     = valid_q && sljf_pkg::goes_before(ctrl_i.longest_first,
                                                    fresh_i.burst, entry_q.burst);
  assign place   = !found_i && (hit || !valid_q);
  assign found_o = found_i || place;

  // Insert, shift toward the tail, or shift toward the head on a pop.
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (place) begin
        entry_d = fresh_i;
        valid_d = 1'b1;
      end else if (found_i) begin
        entry_d = prev_i;
        valid_d = prev_valid_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

### rtl/sljf_queue.sv
// Row of queue cells kept sorted by burst length, head at cell zero.
`default_nettype none

module sljf_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  sljf_pkg::ctrl_t   ctrl_i,
  input  sljf_pkg::entry_t  fresh_i,
  output sljf_pkg::entry_t  head_o,
  output logic              empty_o,
  output logic              full_o
);

  sljf_pkg::entry_t entry  [sljf_pkg::QueueDepth];
  logic             valid  [sljf_pkg::QueueDepth];
  logic             found  [sljf_pkg::QueueDepth+1];

  assign found[0] = 1'b0;

  // Each cell sees its neighbors on both sides; the ends see empty slots.
  for (genvar k = 0; k < sljf_pkg::QueueDepth; k++) begin : g_cell
    sljf_pkg::entry_t prev_e, next_e;
    logic             prev_v, next_v;

    if (k == 0) begin : g_first
      assign prev_e = '0;
      assign prev_v = 1'b0;
    end else begin : g_mid_prev
      assign prev_e = entry[k-1];
      assign prev_v = valid[k-1];
    end

    if (k == sljf_pkg::QueueDepth - 1) begin : g_last
      assign next_e = '0;
      assign next_v = 1'b0;
    end else begin : g_mid_next
      assign next_e = entry[k+1];
      assign next_v = valid[k+1];
    end

    sljf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .fresh_i      (fresh_i),
      .prev_i       (prev_e),
      .prev_valid_i (prev_v),
      .next_i       (next_e),
      .next_valid_i (next_v),
      .found_i      (found[k]),
      .found_o      (found[k+1]),
      .entry_o      (entry[k]),
      .valid_o      (valid[k])
    );
  end

  assign head_o  = entry[0];
  assign empty_o = !valid[0];
  assign full_o  = valid[sljf_pkg::QueueDepth-1];

endmodule

`default_nettype wire
